### src/mced_pkg.sv
// Package for the Morse code encoder/decoder unit.
// Payload and queue entry types, ASCII codes, letter code tables and lookup.
// No dependencies.
package mced_pkg;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;
    localparam int NUM_LETTERS = 26;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    localparam logic [2:0] MAX_SYMBOLS = 3'd4;

    localparam logic [2:0] CODE_LEN [NUM_LETTERS] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
        3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
    };
    localparam logic [3:0] CODE_BITS [NUM_LETTERS] = '{
        4'd2, 4'd1, 4'd5, 4'd1, 4'd0, 4'd4, 4'd3, 4'd0, 4'd0, 4'd14, 4'd5, 4'd2, 4'd3,
        4'd1, 4'd7, 4'd6, 4'd11, 4'd2, 4'd0, 4'd1, 4'd4, 4'd8, 4'd6, 4'd9, 4'd13, 4'd3
    };

    typedef struct packed {
        logic [7:0] in_char;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_of_run;
    } out_item_t;

    // One queued run: either a Morse pattern plus trailing space, or a
    // literal character repeated cnt times.
    typedef struct packed {
        logic       is_morse;
        logic [2:0] cnt;
        logic [3:0] bits;
        logic [7:0] ch;
    } run_desc_t;

    typedef struct packed {
        logic       found;
        logic [4:0] idx;
    } lookup_t;

    function automatic lookup_t morse_lookup(input logic [2:0] cnt, input logic [3:0] bits);
        lookup_t    res;
        logic [3:0] mask;
        res = '0;
        for (int j = 0; j < 4; j++)
        begin
            mask[j] = (3'(j) < cnt);
        end
        for (int k = NUM_LETTERS - 1; k >= 0; k--)
        begin
            if (CODE_LEN[k] == cnt && CODE_BITS[k] == (bits & mask))
            begin
                res.found = 1'b1;
                res.idx   = 5'(k);
            end
        end
        return res;
    endfunction

endpackage

### src/mced_front.sv
// Front end: accepts characters, holds direction and decoder state,
// and turns each character into at most one queued output run. Uses mced_pkg.
module mced_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  mced_pkg::in_item_t  in_item,
    input  logic                q_full,
    output logic                push,
    output mced_pkg::run_desc_t push_desc
);
    import mced_pkg::*;

    logic       direction_reg;
    logic [3:0] symbol_bits_reg, symbol_bits_next;
    logic [2:0] symbol_count_reg, symbol_count_next;
    logic       pattern_invalid_reg, pattern_invalid_next;
    logic       space_pending_reg, space_pending_next;

    logic       accept;
    logic       desc_valid;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign push     = accept && desc_valid;

    always_comb
    begin
        logic [7:0] c;
        logic [4:0] k;
        logic [3:0] sb;
        logic [2:0] sc;
        logic       pi;
        logic       sp;
        lookup_t    lk;
        c  = in_item.in_char;
        k  = '0;
        sb = symbol_bits_reg;
        sc = symbol_count_reg;
        pi = pattern_invalid_reg;
        sp = space_pending_reg;
        lk = '0;
        desc_valid = 1'b0;
        push_desc  = '0;
        if (!direction_reg)
        begin
            if (c >= CH_LA && c <= CH_LZ)
            begin
                c = c - CASE_OFS;
            end
            if (c == CH_SPACE)
            begin
                desc_valid   = 1'b1;
                push_desc.ch = CH_SPACE;
                push_desc.cnt = 3'd2;
            end
            else if (c >= CH_UA && c <= CH_UZ)
            begin
                k = 5'(c - CH_UA);
                desc_valid = 1'b1;
                push_desc.is_morse = 1'b1;
                push_desc.cnt  = CODE_LEN[k] + 3'd1;
                push_desc.bits = CODE_BITS[k];
                push_desc.ch   = CH_SPACE;
            end
        end
        else
        begin
            if (c == CH_SPACE)
            begin
                if (sp)
                begin
                    desc_valid    = 1'b1;
                    push_desc.ch  = CH_SPACE;
                    push_desc.cnt = 3'd1;
                    sp = 1'b0;
                end
                else
                begin
                    lk = morse_lookup(sc, sb);
                    if (!pi && sc != 3'd0 && lk.found)
                    begin
                        desc_valid    = 1'b1;
                        push_desc.ch  = CH_UA + {3'b000, lk.idx};
                        push_desc.cnt = 3'd1;
                    end
                    sb = '0;
                    sc = '0;
                    pi = 1'b0;
                    sp = 1'b1;
                end
            end
            else
            begin
                sp = 1'b0;
                if (c == CH_DOT || c == CH_DASH)
                begin
                    if (sc < MAX_SYMBOLS)
                    begin
                        if (c == CH_DASH)
                        begin
                            sb[sc[1:0]] = 1'b1;
                        end
                        sc = sc + 3'd1;
                    end
                    else
                    begin
                        pi = 1'b1;
                    end
                end
                else
                begin
                    pi = 1'b1;
                end
                if (in_item.end_of_message)
                begin
                    lk = morse_lookup(sc, sb);
                    if (!pi && sc != 3'd0 && lk.found)
                    begin
                        desc_valid    = 1'b1;
                        push_desc.ch  = CH_UA + {3'b000, lk.idx};
                        push_desc.cnt = 3'd1;
                    end
                end
            end
        end
        if (in_item.end_of_message)
        begin
            sb = '0;
            sc = '0;
            pi = 1'b0;
            sp = 1'b0;
        end
        symbol_bits_next     = sb;
        symbol_count_next    = sc;
        pattern_invalid_next = pi;
        space_pending_next   = sp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg       <= 1'b0;
            symbol_bits_reg     <= '0;
            symbol_count_reg    <= '0;
            pattern_invalid_reg <= 1'b0;
            space_pending_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                direction_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                symbol_bits_reg     <= symbol_bits_next;
                symbol_count_reg    <= symbol_count_next;
                pattern_invalid_reg <= pattern_invalid_next;
                space_pending_reg   <= space_pending_next;
            end
        end
    end

endmodule

### src/mced_queue.sv
// Short run queue between front and back end.
// Uses mced_pkg for the entry type and depth.
module mced_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  mced_pkg::run_desc_t          push_desc,
    input  logic                         pop,
    output mced_pkg::run_desc_t          head_desc,
    output logic                         full,
    output logic                         nonempty,
    output logic [mced_pkg::QCNT_W-1:0]  count
);
    import mced_pkg::*;

    run_desc_t         mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign head_desc = mem[rd_ptr_reg];
    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign nonempty  = (count_reg != '0);
    assign count     = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### src/mced_back.sv
// Back end: expands the run at the queue head into output characters,
// one per cycle while out_stall is low, into the output register. Uses mced_pkg.
module mced_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_nonempty,
    input  mced_pkg::run_desc_t head_desc,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output mced_pkg::out_item_t out_item
);
    import mced_pkg::*;

    logic [2:0] idx_reg;
    logic       out_valid_reg;
    out_item_t  out_reg;

    logic       load;
    logic       last;
    logic [7:0] ch;

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;
    assign load      = q_nonempty && (!out_valid_reg || !out_stall);
    assign last      = (idx_reg == head_desc.cnt - 3'd1);
    assign pop       = load && last;

    always_comb
    begin
        if (head_desc.is_morse && !last)
        begin
            ch = head_desc.bits[idx_reg[1:0]] ? CH_DASH : CH_DOT;
        end
        else
        begin
            ch = head_desc.ch;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg.out_char    <= ch;
            out_reg.last_of_run <= last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= last ? 3'd0 : idx_reg + 3'd1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

### src/morse_code_encoder_decoder_unit.sv
// Top level of the Morse code encoder/decoder unit.
// Instantiates mced_front, mced_queue and mced_back; uses mced_pkg.

// Translates ASCII text to International Morse code for A-Z (direction 0) or
// Morse back to letters (direction 1). An input transfer is taken every cycle
// while the two-entry run queue has room; the output side delivers one
// character per cycle from the queue head while out_stall is low. An encoded
// letter gives its dots and dashes and a trailing space, a space gives two
// spaces, a decoded letter or word space gives one character, and the
// rest give none. Sustained throughput is set by the output serializer at
// one character per cycle. Write direction only while no transfer is in flight.
module morse_code_encoder_decoder_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  mced_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output mced_pkg::out_item_t out_item
);
    import mced_pkg::*;

    logic              push;
    run_desc_t         push_desc;
    logic              pop;
    run_desc_t         head_desc;
    logic              q_full;
    logic              q_nonempty;
    logic [QCNT_W-1:0] q_count;

    mced_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .q_full      (q_full),
        .push        (push),
        .push_desc   (push_desc)
    );

    mced_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head_desc (head_desc),
        .full      (q_full),
        .nonempty  (q_nonempty),
        .count     (q_count)
    );

    mced_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (q_nonempty),
        .head_desc  (head_desc),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= QCNT_W'(QDEPTH))
        else $error("run queue count exceeds depth");

    a_out_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(q_nonempty))
        else $error("output appeared without a queued run");

    a_out_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.out_char == CH_DOT || out_item.out_char == CH_DASH ||
                       out_item.out_char == CH_SPACE ||
                       (out_item.out_char >= CH_UA && out_item.out_char <= CH_UZ)))
        else $error("illegal output character");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_nonempty)
        else $error("pop from empty run queue");
`endif

endmodule
